// ===== rtl/core/kts_pkg.sv =====
// Shared types, codes and constants of the keyed timing statistics table.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package kts_pkg;

  // Default table geometry
  localparam int KTS_NUM_SLOTS     = 32;
  localparam int KTS_HISTORY_DEPTH = 64;

  // Field widths
  localparam int KEY_W    = 16;
  localparam int SMP_W    = 32;
  localparam int SLOTF_W  = 5;
  localparam int BACK_W   = 6;
  localparam int CNT_F_W  = 32;
  localparam int TOT_W    = 48;
  localparam int STATUS_W = 2;

  // Saturation limits
  localparam logic [CNT_F_W-1:0] CNT_MAX = {CNT_F_W{1'b1}};
  localparam logic [TOT_W-1:0]   TOT_MAX = {TOT_W{1'b1}};

  // Request kinds
  localparam logic FUNC_RECORD  = 1'b0;
  localparam logic FUNC_READOUT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNUSED = 2'd2;

  // Per-slot statistics word
  typedef struct packed {
    logic [CNT_F_W-1:0] count;
    logic [TOT_W-1:0]   total;
    logic [SMP_W-1:0]   min_time;
    logic [SMP_W-1:0]   max_time;
  } stat_t;

  localparam int STAT_W = $bits(stat_t);

  // Key scan status from the key table to the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } scan_t;

  // Staged result, before the history sample joins it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOTF_W-1:0]  slot_used;
    logic                was_new;
    stat_t               stats;
    logic                hist_valid;
  } res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_RSTAT,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/keyed_timing_statistics_table.sv =====
// Top level of the keyed timing statistics table: stream ports, sequencer,
// result staging and output register. Uses kts_pkg, kts_key_table,
// kts_slot_stats and kts_history.
//
//  channel | direction | handshake                | payload
//  in_     | slave     | in_tvalid / in_tready    | in_tuser func, in_tdata fields
//  out_    | master    | out_tvalid / out_tready  | out_tuser status, out_tdata fields
//
// One request at a time. A record scans the key memory from slot 0 up to the
// matching slot or, for a new key, the last slot in use; an empty table skips
// the scan and a full table drops a new key. The key memory is scanned one slot
// per cycle. A readout reads the slot's statistics and history, unless unused.
// Reset clears control state and the slot count only; statistics zero on allocation.
// Input is taken while a result waits; a stalled output holds the next one staged.
`default_nettype none

module keyed_timing_statistics_table #(
  parameter int NUM_SLOTS     = kts_pkg::KTS_NUM_SLOTS,
  parameter int HISTORY_DEPTH = kts_pkg::KTS_HISTORY_DEPTH
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [63:0]  in_tdata,   // key[15:0], sample[47:16], slot[52:48], back[58:53]
  input  wire  [0:0]   in_tuser,   // func[0]
  output logic         out_tvalid,
  input  wire          out_tready,
  // slot_used[4:0], was_new[5], times_called[37:6], total_time[85:38],
  // min_time[117:86], max_time[149:118], history_sample[181:150], history_valid[182]
  output logic [183:0] out_tdata,
  output logic [1:0]   out_tuser   // status[1:0]
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int HP_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CMP_W  = (CNT_W > kts_pkg::SLOTF_W) ? CNT_W : kts_pkg::SLOTF_W;

  kts_pkg::state_t state_r, state_nxt;

  // Request fields
  logic                         in_func;
  logic [kts_pkg::KEY_W-1:0]    in_key;
  logic [kts_pkg::SMP_W-1:0]    in_sample;
  logic [kts_pkg::SLOTF_W-1:0]  in_slot;
  logic [kts_pkg::BACK_W-1:0]   in_back;

  // Held request and working state
  logic [kts_pkg::KEY_W-1:0]    key_r;
  logic [kts_pkg::SMP_W-1:0]    sample_r;
  logic [kts_pkg::BACK_W-1:0]   back_r;
  logic [SLOT_W-1:0]            slot_r;
  logic                         fresh_r;
  logic [CNT_W-1:0]             in_use_r;
  kts_pkg::res_t                res_r, res_nxt;

  // Output register
  logic                         out_valid_r;
  kts_pkg::res_t                out_res_r;
  logic [kts_pkg::SMP_W-1:0]    out_hist_r;

  // Control
  logic                         accept;
  logic                         ro_unused;
  logic                         in_use_zero;
  logic                         table_full;
  logic                         fin_go;
  logic                         scan_start;
  logic                         stat_rd_en;
  logic [SLOT_W-1:0]            stat_rd_addr;
  logic                         stat_wr_en;
  logic                         hist_rd_en;
  logic                         res_load;

  // Submodule links
  kts_pkg::scan_t               scan;
  logic [SLOT_W-1:0]            scan_idx;
  kts_pkg::stat_t               cur;
  kts_pkg::stat_t               nxt;
  logic [HP_W-1:0]              cur_ptr;
  logic                         cnt_sat;
  logic                         hvalid;
  logic [kts_pkg::SMP_W-1:0]    hist_data;

  // Unpack the request
  assign in_func   = in_tuser[0];
  assign in_key    = in_tdata[15:0];
  assign in_sample = in_tdata[47:16];
  assign in_slot   = in_tdata[52:48];
  assign in_back   = in_tdata[58:53];

  assign accept      = in_tvalid && in_tready;
  assign ro_unused   = (CMP_W'(in_slot) >= CMP_W'(in_use_r));
  assign in_use_zero = (in_use_r == '0);
  assign table_full  = (in_use_r == CNT_W'(NUM_SLOTS));
  assign fin_go      = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kts_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == kts_pkg::FUNC_READOUT) begin
            state_nxt = ro_unused ? kts_pkg::ST_FIN : kts_pkg::ST_RSTAT;
          end else begin
            state_nxt = in_use_zero ? kts_pkg::ST_UPD : kts_pkg::ST_SCAN;
          end
        end
      end
      kts_pkg::ST_SCAN: begin
        if (scan.done) begin
          state_nxt = (!scan.hit && table_full) ? kts_pkg::ST_FIN : kts_pkg::ST_UPD;
        end
      end
      kts_pkg::ST_UPD:   state_nxt = kts_pkg::ST_FIN;
      kts_pkg::ST_RSTAT: state_nxt = kts_pkg::ST_FIN;
      kts_pkg::ST_FIN: begin
        if (fin_go) begin
          state_nxt = kts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kts_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready    = 1'b0;
    scan_start   = 1'b0;
    stat_rd_en   = 1'b0;
    stat_rd_addr = scan_idx;
    stat_wr_en   = 1'b0;
    hist_rd_en   = 1'b0;
    res_load     = 1'b0;
    unique case (state_r)
      kts_pkg::ST_IDLE: begin
        in_tready    = 1'b1;
        stat_rd_addr = SLOT_W'(in_slot);
        if (accept) begin
          if (in_func == kts_pkg::FUNC_READOUT) begin
            stat_rd_en = !ro_unused;
            res_load   = ro_unused;
          end else begin
            scan_start = !in_use_zero;
          end
        end
      end
      kts_pkg::ST_SCAN: begin
        stat_rd_en = scan.done && scan.hit;
        res_load   = scan.done && !scan.hit && table_full;
      end
      kts_pkg::ST_UPD: begin
        stat_wr_en = 1'b1;
        res_load   = 1'b1;
      end
      kts_pkg::ST_RSTAT: begin
        hist_rd_en = 1'b1;
        res_load   = 1'b1;
      end
      kts_pkg::ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Staged result contents per finishing state
  always_comb begin
    res_nxt = '0;
    case (state_r)
      kts_pkg::ST_IDLE: begin
        res_nxt.status    = kts_pkg::STATUS_UNUSED;
        res_nxt.slot_used = in_slot;
      end
      kts_pkg::ST_SCAN: begin
        res_nxt.status = kts_pkg::STATUS_FULL;
      end
      kts_pkg::ST_UPD: begin
        res_nxt.status    = kts_pkg::STATUS_OK;
        res_nxt.slot_used = kts_pkg::SLOTF_W'(slot_r);
        res_nxt.was_new   = fresh_r;
        res_nxt.stats     = nxt;
      end
      kts_pkg::ST_RSTAT: begin
        res_nxt.status     = kts_pkg::STATUS_OK;
        res_nxt.slot_used  = kts_pkg::SLOTF_W'(slot_r);
        res_nxt.stats      = cur;
        res_nxt.hist_valid = hvalid;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kts_pkg::ST_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (stat_wr_en && fresh_r) begin
        in_use_r <= in_use_r + CNT_W'(1);
      end
      if ((state_r == kts_pkg::ST_FIN) && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request and the slot it works on
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r    <= in_key;
      sample_r <= in_sample;
      back_r   <= in_back;
      fresh_r  <= in_use_zero;
      slot_r   <= (in_func == kts_pkg::FUNC_READOUT) ? SLOT_W'(in_slot) : '0;
    end else if ((state_r == kts_pkg::ST_SCAN) && scan.done) begin
      fresh_r <= !scan.hit;
      slot_r  <= scan.hit ? scan_idx : SLOT_W'(in_use_r);
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  // Output register: load the staged result, history sample only when valid
  always_ff @(posedge clk) begin
    if ((state_r == kts_pkg::ST_FIN) && fin_go) begin
      out_res_r  <= res_r;
      out_hist_r <= res_r.hist_valid ? hist_data : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0,
                       out_res_r.hist_valid,
                       out_hist_r,
                       out_res_r.stats.max_time,
                       out_res_r.stats.min_time,
                       out_res_r.stats.total,
                       out_res_r.stats.count,
                       out_res_r.was_new,
                       out_res_r.slot_used};

  kts_key_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W),
    .CNT_W     (CNT_W)
  ) u_key_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .key     (key_r),
    .in_use  (in_use_r),
    .wr_en   (stat_wr_en && fresh_r),
    .wr_addr (slot_r),
    .wr_key  (key_r),
    .scan    (scan),
    .idx     (scan_idx)
  );

  kts_slot_stats #(
    .NUM_SLOTS     (NUM_SLOTS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SLOT_W        (SLOT_W),
    .HP_W          (HP_W)
  ) u_slot_stats (
    .clk     (clk),
    .rd_en   (stat_rd_en),
    .rd_addr (stat_rd_addr),
    .fresh   (fresh_r && (state_r == kts_pkg::ST_UPD)),
    .sample  (sample_r),
    .wr_en   (stat_wr_en),
    .wr_addr (slot_r),
    .cur     (cur),
    .cur_ptr (cur_ptr),
    .nxt     (nxt),
    .cnt_sat (cnt_sat)
  );

  kts_history #(
    .NUM_SLOTS     (NUM_SLOTS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SLOT_W        (SLOT_W),
    .HP_W          (HP_W)
  ) u_history (
    .clk      (clk),
    .wr_en    (stat_wr_en && !cnt_sat),
    .wr_slot  (slot_r),
    .wr_ptr   (cur_ptr),
    .wr_data  (sample_r),
    .rd_en    (hist_rd_en),
    .rd_slot  (slot_r),
    .rd_ptr   (cur_ptr),
    .rd_count (cur.count),
    .rd_back  (back_r),
    .hvalid   (hvalid),
    .rd_data  (hist_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/kts_key_table.sv =====
// Key memory of the statistics table and its sequential key scan.
// Uses kts_pkg for widths and the scan status struct.
`default_nettype none

module kts_key_table #(
  parameter int NUM_SLOTS = kts_pkg::KTS_NUM_SLOTS,
  parameter int SLOT_W    = 1,
  parameter int CNT_W     = 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [kts_pkg::KEY_W-1:0]    key,
  input  wire  [CNT_W-1:0]             in_use,
  input  wire                          wr_en,
  input  wire  [SLOT_W-1:0]            wr_addr,
  input  wire  [kts_pkg::KEY_W-1:0]    wr_key,
  output kts_pkg::scan_t               scan,
  output logic [SLOT_W-1:0]            idx
);

  logic [kts_pkg::KEY_W-1:0] key_mem [NUM_SLOTS];
  logic [kts_pkg::KEY_W-1:0] key_rdata_r;
  logic                      scanning_r;
  logic [SLOT_W-1:0]         idx_r;
  logic [CNT_W-1:0]          idx_p1;
  logic [SLOT_W-1:0]         raddr;
  logic                      hit;
  logic                      last;

  // Compare the entry read last cycle; stop on a match or at the last slot in use
  assign idx_p1    = CNT_W'(idx_r) + CNT_W'(1);
  assign hit       = scanning_r && (key_rdata_r == key);
  assign last      = (idx_p1 == in_use);
  assign scan.done = scanning_r && (hit || last);
  assign scan.hit  = hit;
  assign idx       = idx_r;

  // Read slot 0 on start, then the slot after the one under compare
  assign raddr = start ? '0 : idx_p1[SLOT_W-1:0];

  // Scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
    end else if (start) begin
      scanning_r <= 1'b1;
    end else if (scan.done) begin
      scanning_r <= 1'b0;
    end
  end

  // Advance the slot under compare
  always_ff @(posedge clk) begin
    if (start) begin
      idx_r <= '0;
    end else if (scanning_r && !scan.done) begin
      idx_r <= idx_p1[SLOT_W-1:0];
    end
  end

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    key_rdata_r <= key_mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/kts_slot_stats.sv =====
// Per-slot statistics memory with its read-modify-write update logic.
// Uses kts_pkg for the statistics word and saturation limits.
`default_nettype none

module kts_slot_stats #(
  parameter int NUM_SLOTS     = kts_pkg::KTS_NUM_SLOTS,
  parameter int HISTORY_DEPTH = kts_pkg::KTS_HISTORY_DEPTH,
  parameter int SLOT_W        = 1,
  parameter int HP_W          = 1
) (
  input  wire                          clk,
  input  wire                          rd_en,
  input  wire  [SLOT_W-1:0]            rd_addr,
  input  wire                          fresh,
  input  wire  [kts_pkg::SMP_W-1:0]    sample,
  input  wire                          wr_en,
  input  wire  [SLOT_W-1:0]            wr_addr,
  output kts_pkg::stat_t               cur,
  output logic [HP_W-1:0]              cur_ptr,
  output kts_pkg::stat_t               nxt,
  output logic                         cnt_sat
);

  localparam int WORD_W = HP_W + kts_pkg::STAT_W;

  logic [WORD_W-1:0]            stat_mem [NUM_SLOTS];
  logic [WORD_W-1:0]            rdata_r;
  logic [HP_W-1:0]              nxt_ptr;
  logic [kts_pkg::TOT_W:0]      sum;

  // A freshly allocated slot starts from all zeros
  always_comb begin
    if (fresh) begin
      cur     = '0;
      cur_ptr = '0;
    end else begin
      cur     = rdata_r[kts_pkg::STAT_W-1:0];
      cur_ptr = rdata_r[WORD_W-1:kts_pkg::STAT_W];
    end
  end

  // Fold the sample in: saturating total and count, ring pointer, min and max
  assign sum     = {1'b0, cur.total} + (kts_pkg::TOT_W + 1)'(sample);
  assign cnt_sat = (cur.count == kts_pkg::CNT_MAX);

  always_comb begin
    nxt       = cur;
    nxt_ptr   = cur_ptr;
    nxt.total = sum[kts_pkg::TOT_W] ? kts_pkg::TOT_MAX : sum[kts_pkg::TOT_W-1:0];
    if (!cnt_sat) begin
      nxt.count = cur.count + kts_pkg::CNT_F_W'(1);
      if (cur_ptr == HP_W'(HISTORY_DEPTH - 1)) begin
        nxt_ptr = '0;
      end else begin
        nxt_ptr = cur_ptr + HP_W'(1);
      end
    end
    if ((sample != '0) && ((cur.min_time == '0) || (cur.min_time > sample))) begin
      nxt.min_time = sample;
    end
    if (cur.max_time < sample) begin
      nxt.max_time = sample;
    end
  end

  // Statistics memory: write back the updated word, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stat_mem[wr_addr] <= {nxt_ptr, nxt};
    end
    if (rd_en) begin
      rdata_r <= stat_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kts_history.sv =====
// History ring memory of all slots with its write and readout addressing.
// Uses kts_pkg for field widths.
`default_nettype none

module kts_history #(
  parameter int NUM_SLOTS     = kts_pkg::KTS_NUM_SLOTS,
  parameter int HISTORY_DEPTH = kts_pkg::KTS_HISTORY_DEPTH,
  parameter int SLOT_W        = 1,
  parameter int HP_W          = 1
) (
  input  wire                           clk,
  input  wire                           wr_en,
  input  wire  [SLOT_W-1:0]             wr_slot,
  input  wire  [HP_W-1:0]               wr_ptr,
  input  wire  [kts_pkg::SMP_W-1:0]     wr_data,
  input  wire                           rd_en,
  input  wire  [SLOT_W-1:0]             rd_slot,
  input  wire  [HP_W-1:0]               rd_ptr,
  input  wire  [kts_pkg::CNT_F_W-1:0]   rd_count,
  input  wire  [kts_pkg::BACK_W-1:0]    rd_back,
  output logic                          hvalid,
  output logic [kts_pkg::SMP_W-1:0]     rd_data
);

  localparam int DEPTH = NUM_SLOTS * HISTORY_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = HP_W + 2;

  logic [kts_pkg::SMP_W-1:0] hist_mem [DEPTH];
  logic [kts_pkg::SMP_W-1:0] rd_data_r;
  logic [SW-1:0]             back_pos;
  logic [SW-1:0]             back_mod;
  logic [AW:0]               wr_full;
  logic [AW:0]               rd_full;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             rd_addr;

  // Offset is in range below both the count and the ring depth
  assign hvalid = (kts_pkg::CNT_F_W'(rd_back) < rd_count) &&
                  (kts_pkg::CNT_F_W'(rd_back) < kts_pkg::CNT_F_W'(HISTORY_DEPTH));

  // Newest entry sits one before the write pointer; step back from there
  assign back_pos = SW'(rd_ptr) + SW'(HISTORY_DEPTH - 1) - SW'(rd_back);
  assign back_mod = (back_pos >= SW'(HISTORY_DEPTH)) ? (back_pos - SW'(HISTORY_DEPTH))
                                                      : back_pos;

  // Ring base of a slot plus the position within it
  assign wr_full = (AW + 1)'(wr_slot) * (AW + 1)'(HISTORY_DEPTH) + (AW + 1)'(wr_ptr);
  assign rd_full = (AW + 1)'(rd_slot) * (AW + 1)'(HISTORY_DEPTH)
                 + (AW + 1)'(back_mod[HP_W-1:0]);
  assign wr_addr = wr_full[AW-1:0];
  assign rd_addr = rd_full[AW-1:0];

  assign rd_data = rd_data_r;

  // History memory: one write port, registered read held until the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en && hvalid) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
